@@ hdl/kabe_pkg.sv @@
// Shared types, register indexes and fixed-point helpers for the angle/bias estimator.
`timescale 1ns / 1ps
package kabe_pkg;

    localparam int DW = 32;   // value width
    localparam int PW = 35;   // rounded product width
    localparam int WW = 40;   // working width for sums
    localparam int RW = 31;   // configuration register width
    localparam int AW = 8;    // register index width

    localparam logic [AW-1:0] REG_QA = 8'd0;
    localparam logic [AW-1:0] REG_QB = 8'd1;
    localparam logic [AW-1:0] REG_R  = 8'd2;
    localparam logic [AW-1:0] REG_DT = 8'd3;

    localparam logic [RW-1:0] QA_RST = 31'd1073742;
    localparam logic [RW-1:0] QB_RST = 31'd3221225;
    localparam logic [RW-1:0] R_RST  = 31'd32212255;
    localparam logic [RW-1:0] DT_RST = 31'd10737418;

    localparam logic signed [WW-1:0] SAT_HI = 40'sh00_7fff_ffff;
    localparam logic signed [WW-1:0] SAT_LO = 40'shff_8000_0000;

    function automatic logic signed [WW-1:0] ext32(input logic signed [DW-1:0] v);
        return {{(WW-DW){v[DW-1]}}, v};
    endfunction

    function automatic logic signed [WW-1:0] ext35(input logic signed [PW-1:0] v);
        return {{(WW-PW){v[PW-1]}}, v};
    endfunction

    function automatic logic signed [WW-1:0] extu(input logic [RW-1:0] v);
        return {{(WW-RW){1'b0}}, v};
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [WW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[DW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[DW-1:0];
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/kabe_mul.sv @@
// Bit-serial signed multiplier, product scaled by 2^30 with round half away from zero.
`timescale 1ns / 1ps
module kabe_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [kabe_pkg::DW-1:0] a,
    input  logic signed [kabe_pkg::DW-1:0] b,
    output logic                         done,
    output logic signed [kabe_pkg::PW-1:0] p
);
    import kabe_pkg::*;

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_RND} mstate_t;

    mstate_t          state_reg;
    logic [DW-1:0]    mag_a_reg;
    logic [DW-1:0]    mag_b_reg;
    logic [2*DW-1:0]  acc_reg;
    logic [4:0]       cnt_reg;
    logic             neg_reg;
    logic             done_reg;
    logic signed [PW-1:0] p_reg;

    logic [DW:0]      sum;
    logic [2*DW-1:0]  rnd;
    logic [PW-1:0]    mag;

    assign sum  = {1'b0, acc_reg[2*DW-1:DW]} + (mag_b_reg[0] ? {1'b0, mag_a_reg} : '0);
    assign rnd  = acc_reg + 64'd536870912;
    assign mag  = {1'b0, rnd[2*DW-1:30]};
    assign done = done_reg;
    assign p    = p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        mag_a_reg <= a[DW-1] ? DW'(-a) : DW'(a);
                        mag_b_reg <= b[DW-1] ? DW'(-b) : DW'(b);
                        neg_reg   <= a[DW-1] ^ b[DW-1];
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN: begin
                    acc_reg   <= {sum, acc_reg[DW-1:1]};
                    mag_b_reg <= {1'b0, mag_b_reg[DW-1:1]};
                    cnt_reg   <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= M_RND;
                    end
                end
                M_RND: begin
                    p_reg     <= neg_reg ? -$signed(mag) : $signed(mag);
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/kabe_div.sv @@
// Bit-serial restoring divider for the gains: sat32((num * 2^30) / den), den positive.
`timescale 1ns / 1ps
module kabe_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [kabe_pkg::DW-1:0] num,
    input  logic [kabe_pkg::DW:0]          den,
    output logic                           done,
    output logic signed [kabe_pkg::DW-1:0] q
);
    import kabe_pkg::*;

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t            state_reg;
    logic [DW+29:0]     dvd_reg;
    logic [DW:0]        den_reg;
    logic [DW:0]        rem_reg;
    logic [DW-1:0]      quo_reg;
    logic               ovf_reg;
    logic               neg_reg;
    logic [5:0]         cnt_reg;
    logic               done_reg;
    logic signed [DW-1:0] q_reg;

    logic [DW+1:0]      r2;
    logic [DW+1:0]      diff;
    logic               ge;
    logic               big;

    assign r2   = {rem_reg, dvd_reg[DW+29]};
    assign diff = r2 - {1'b0, den_reg};
    assign ge   = !diff[DW+1];
    assign big  = ovf_reg || quo_reg[DW-1];
    assign done = done_reg;
    assign q    = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        dvd_reg   <= {(num[DW-1] ? DW'(-num) : DW'(num)), 30'd0};
                        neg_reg   <= num[DW-1];
                        den_reg   <= den;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        ovf_reg   <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    rem_reg   <= ge ? diff[DW:0] : r2[DW:0];
                    quo_reg   <= {quo_reg[DW-2:0], ge};
                    ovf_reg   <= ovf_reg | quo_reg[DW-1];
                    dvd_reg   <= {dvd_reg[DW+28:0], 1'b0};
                    cnt_reg   <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd61) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    if (neg_reg) begin
                        q_reg <= big ? SAT_LO[DW-1:0] : -$signed(quo_reg);
                    end else begin
                        q_reg <= big ? SAT_HI[DW-1:0] : $signed(quo_reg);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

endmodule

@@ hdl/kalman_angle_bias_estimator_top.sv @@
// Two-state Kalman angle and gyro-bias estimator with a bit-serial multiplier and divider.
// Per sample: ten serial products, two serial gain divisions and the sequencing
// states S_RATE, S_CHK and S_OUT; the divisions are skipped when S is not positive.
// One sample in flight: the next is taken only after the previous result is loaded.
// The next sample is taken while the previous result waits on the master side.
// Reset (aresetn low, synchronous): state and covariance clear, registers take defaults.
`timescale 1ns / 1ps
module kalman_angle_bias_estimator_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [63:0]                 s_tdata,   // gyro_rate, measured_angle
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,   // angle_estimate, corrected_rate
    input  logic                        cfg_we,
    input  logic [kabe_pkg::AW-1:0]     cfg_addr,
    input  logic [kabe_pkg::RW-1:0]     cfg_wdata
);
    import kabe_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RATE, S_M_ANG, S_M_T, S_M_P00, S_M_P11, S_CHK, S_DIV0, S_DIV1,
        S_M_K0Y, S_M_K1Y, S_M_C10, S_M_C00, S_M_C11, S_M_C01, S_OUT
    } state_t;

    state_t               state_reg;
    logic                 issued_reg;
    logic [RW-1:0]        qa_reg, qb_reg, r_reg, dt_reg;
    logic signed [DW-1:0] gyro_reg, meas_reg, angle_s_reg, bias_reg;
    logic signed [DW-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [DW-1:0] rate_reg, angle_p_reg, inc_reg, y_reg, k0_reg, k1_reg;
    logic [DW:0]          s_reg;
    logic                 m_tvalid_reg;
    logic [63:0]          m_tdata_reg;

    logic                 is_mul, is_div;
    logic                 mul_start, mul_done, div_start, div_done;
    logic signed [DW-1:0] mul_a, mul_b, div_num, div_q;
    logic signed [PW-1:0] mul_p;
    logic signed [WW-1:0] m_ext, m_sat;
    logic signed [DW+1:0] s_sum;
    logic                 out_load;

    always_comb begin
        is_mul = 1'b0;
        is_div = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        div_num = p00_reg;
        unique case (state_reg)
            S_M_ANG: begin is_mul = 1'b1; mul_a = {1'b0, dt_reg}; mul_b = rate_reg; end
            S_M_T:   begin is_mul = 1'b1; mul_a = {1'b0, dt_reg}; mul_b = p11_reg; end
            S_M_P00: begin is_mul = 1'b1; mul_a = {1'b0, dt_reg}; mul_b = inc_reg; end
            S_M_P11: begin is_mul = 1'b1; mul_a = {1'b0, qb_reg}; mul_b = {1'b0, dt_reg}; end
            S_M_K0Y: begin is_mul = 1'b1; mul_a = k0_reg; mul_b = y_reg; end
            S_M_K1Y: begin is_mul = 1'b1; mul_a = k1_reg; mul_b = y_reg; end
            S_M_C10: begin is_mul = 1'b1; mul_a = k1_reg; mul_b = p00_reg; end
            S_M_C00: begin is_mul = 1'b1; mul_a = k0_reg; mul_b = p00_reg; end
            S_M_C11: begin is_mul = 1'b1; mul_a = k1_reg; mul_b = p01_reg; end
            S_M_C01: begin is_mul = 1'b1; mul_a = k0_reg; mul_b = p01_reg; end
            S_DIV0:  begin is_div = 1'b1; div_num = p00_reg; end
            S_DIV1:  begin is_div = 1'b1; div_num = p10_reg; end
            default: begin end
        endcase
    end

    assign mul_start = is_mul && !issued_reg;
    assign div_start = is_div && !issued_reg;
    assign m_ext     = ext35(mul_p);
    assign m_sat     = ext32(sat32(m_ext));
    assign s_sum     = {{2{p00_reg[DW-1]}}, p00_reg} + {3'b000, r_reg};
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    kabe_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    kabe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (s_reg),
        .done    (div_done),
        .q       (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            issued_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            qa_reg       <= QA_RST;
            qb_reg       <= QB_RST;
            r_reg        <= R_RST;
            dt_reg       <= DT_RST;
            angle_s_reg  <= '0;
            bias_reg     <= '0;
            p00_reg      <= '0;
            p01_reg      <= '0;
            p10_reg      <= '0;
            p11_reg      <= '0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_QA:  qa_reg <= cfg_wdata;
                    REG_QB:  qb_reg <= cfg_wdata;
                    REG_R:   r_reg  <= cfg_wdata;
                    REG_DT:  dt_reg <= cfg_wdata;
                    default: begin end
                endcase
            end
            if (mul_start || div_start) begin
                issued_reg <= 1'b1;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        gyro_reg  <= s_tdata[31:0];
                        meas_reg  <= s_tdata[63:32];
                        state_reg <= S_RATE;
                    end
                end
                S_RATE: begin
                    rate_reg  <= sat32(ext32(gyro_reg) - ext32(bias_reg));
                    state_reg <= S_M_ANG;
                end
                S_M_ANG: if (mul_done) begin
                    angle_p_reg <= sat32(ext32(angle_s_reg) + m_sat);
                    issued_reg  <= 1'b0;
                    state_reg   <= S_M_T;
                end
                S_M_T: if (mul_done) begin
                    inc_reg    <= sat32(m_ext - ext32(p01_reg) - ext32(p10_reg)
                                        + extu(qa_reg));
                    p01_reg    <= sat32(ext32(p01_reg) - m_ext);
                    p10_reg    <= sat32(ext32(p10_reg) - m_ext);
                    issued_reg <= 1'b0;
                    state_reg  <= S_M_P00;
                end
                S_M_P00: if (mul_done) begin
                    p00_reg    <= sat32(ext32(p00_reg) + m_ext);
                    issued_reg <= 1'b0;
                    state_reg  <= S_M_P11;
                end
                S_M_P11: if (mul_done) begin
                    p11_reg    <= sat32(ext32(p11_reg) + m_ext);
                    issued_reg <= 1'b0;
                    state_reg  <= S_CHK;
                end
                S_CHK: begin
                    y_reg  <= sat32(ext32(meas_reg) - ext32(angle_p_reg));
                    s_reg  <= s_sum[DW:0];
                    k0_reg <= '0;
                    k1_reg <= '0;
                    if (!s_sum[DW+1] && (s_sum != '0)) begin
                        state_reg <= S_DIV0;
                    end else begin
                        state_reg <= S_M_K0Y;
                    end
                end
                S_DIV0: if (div_done) begin
                    k0_reg     <= div_q;
                    issued_reg <= 1'b0;
                    state_reg  <= S_DIV1;
                end
                S_DIV1: if (div_done) begin
                    k1_reg     <= div_q;
                    issued_reg <= 1'b0;
                    state_reg  <= S_M_K0Y;
                end
                S_M_K0Y: if (mul_done) begin
                    angle_p_reg <= sat32(ext32(angle_p_reg) + m_sat);
                    issued_reg  <= 1'b0;
                    state_reg   <= S_M_K1Y;
                end
                S_M_K1Y: if (mul_done) begin
                    bias_reg   <= sat32(ext32(bias_reg) + m_sat);
                    issued_reg <= 1'b0;
                    state_reg  <= S_M_C10;
                end
                S_M_C10: if (mul_done) begin
                    p10_reg    <= sat32(ext32(p10_reg) - m_ext);
                    issued_reg <= 1'b0;
                    state_reg  <= S_M_C00;
                end
                S_M_C00: if (mul_done) begin
                    p00_reg    <= sat32(ext32(p00_reg) - m_ext);
                    issued_reg <= 1'b0;
                    state_reg  <= S_M_C11;
                end
                S_M_C11: if (mul_done) begin
                    p11_reg    <= sat32(ext32(p11_reg) - m_ext);
                    issued_reg <= 1'b0;
                    state_reg  <= S_M_C01;
                end
                S_M_C01: if (mul_done) begin
                    p01_reg    <= sat32(ext32(p01_reg) - m_ext);
                    issued_reg <= 1'b0;
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        angle_s_reg  <= angle_p_reg;
                        m_tdata_reg  <= {rate_reg, angle_p_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
